// File: sv/itoa_pkg.sv
// Types and constants shared by the integer-to-ASCII formatter.
// Request and response payload structs, ASCII codes and mode codes.
// No dependencies.
package itoa_pkg;

   // Request payload: one number to format
   typedef struct packed {
      logic [63:0] value;
      logic        mode;
      logic        uppercase;
      logic        prefix;
   } req_type;

   // Response payload: one character
   typedef struct packed {
      logic [6:0] char_code;
      logic       last;
   } rsp_type;

   // Mode codes
   localparam logic MODE_DEC = 1'b0;
   localparam logic MODE_HEX = 1'b1;

   // ASCII codes
   localparam logic [6:0] CHAR_ZERO   = 7'h30;
   localparam logic [6:0] CHAR_MINUS  = 7'h2D;
   localparam logic [6:0] CHAR_X      = 7'h78;
   localparam logic [6:0] ALPHA_UPPER = 7'd55;  // 'A' - 10
   localparam logic [6:0] ALPHA_LOWER = 7'd87;  // 'a' - 10

endpackage

// File: sv/integer_to_ascii_formatter_unit.sv
// Integer-to-ASCII formatter, top level: signed decimal and hex output.
// Uses itoa_pkg for payload types, mode codes and ASCII constants.
//
// Formats one number at a time and emits one ASCII character per response,
// most significant digit first, with last set on the final character. A
// request is taken in the idle cycle. In decimal mode it then runs a
// bit-serial binary-to-BCD conversion (one shift-and-adjust step per bit
// through the digit register), then drops leading zero digits (up to
// DEC_DIGITS-1) and emits the characters. In hex mode the conversion is
// skipped: leading zeros are dropped (up to HEX_DIGITS-1), then the
// characters are emitted. Characters leave at one per cycle while rsp_ready
// stays high. The sequencer goes idle once the last character of the number
// sits in the output register, and no new request is taken before then.
module integer_to_ascii_formatter_unit
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Digit counts: decimal digits of 2^VALUE_BITS-1, and hex digits
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int DIG_W      = DEC_DIGITS * 4;
   localparam int HEX_W      = HEX_DIGITS * 4;
   localparam int HEX_SHIFT  = (DEC_DIGITS - HEX_DIGITS) * 4;
   localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
   localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);

   // State codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [DIG_W-1:0]      dig_ff, dig_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]  dig_cnt_ff, dig_cnt_in;
   logic [1:0]            pre_cnt_ff, pre_cnt_in;
   logic                  mode_ff, mode_in;
   logic                  upper_ff, upper_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  out_free;
   logic                  out_load;
   rsp_type               out_char;
   logic [DIG_W-1:0]      dig_adj;
   logic                  bcd_ok;
   logic [3:0]            top_dig;
   logic [VALUE_BITS-1:0] raw_val;
   logic                  raw_neg;
   logic [HEX_W-1:0]      hex_pad;
   logic [6:0]            dig_char;
   logic [6:0]            pre_char;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign top_dig   = dig_ff[DIG_W-1 -: 4];
   assign raw_val   = req_data.value[VALUE_BITS-1:0];
   assign raw_neg   = raw_val[VALUE_BITS-1];
   assign hex_pad   = HEX_W'(raw_val);

   // Add 3 to every BCD digit of 5 or more before the shift; flag bad digits
   always_comb begin
      logic [3:0] cur;
      dig_adj = '0;
      bcd_ok  = 1'b1;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         cur = dig_ff[i*4 +: 4];
         dig_adj[i*4 +: 4] = (cur >= 4'd5) ? cur + 4'd3 : cur;
         if (cur > 4'd9) begin
            bcd_ok = 1'b0;
         end
      end
   end

   // Character for the top digit and for the pending prefix
   always_comb begin
      if (mode_ff == MODE_HEX && top_dig > 4'd9) begin
         dig_char = {3'b000, top_dig} + (upper_ff ? ALPHA_UPPER : ALPHA_LOWER);
      end else begin
         dig_char = {3'b000, top_dig} + CHAR_ZERO;
      end
      if (mode_ff == MODE_HEX) begin
         pre_char = (pre_cnt_ff == 2'd2) ? CHAR_ZERO : CHAR_X;
      end else begin
         pre_char = CHAR_MINUS;
      end
   end

   // Sequencer: load, convert, drop leading zeros, emit
   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      dig_in     = dig_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      pre_cnt_in = pre_cnt_ff;
      mode_in    = mode_ff;
      upper_in   = upper_ff;
      out_load   = 1'b0;
      out_char   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in    = req_data.mode;
               upper_in   = req_data.uppercase;
               dig_cnt_in = DIG_CNT_W'(DEC_DIGITS);
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS);
               if (req_data.mode == MODE_HEX) begin
                  dig_in     = DIG_W'(hex_pad) << HEX_SHIFT;
                  dig_cnt_in = DIG_CNT_W'(HEX_DIGITS);
                  pre_cnt_in = req_data.prefix ? 2'd2 : 2'd0;
                  state_in   = ST_SKIP;
               end else begin
                  dig_in     = '0;
                  mag_in     = raw_neg ? (~raw_val + 1'b1) : raw_val;
                  pre_cnt_in = raw_neg ? 2'd1 : 2'd0;
                  state_in   = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            dig_in     = {dig_adj[DIG_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in     = mag_ff << 1;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_dig == 4'd0 && dig_cnt_ff > DIG_CNT_W'(1)) begin
               dig_in     = dig_ff << 4;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (pre_cnt_ff != 2'd0) begin
                  out_char.char_code = pre_char;
                  out_char.last      = 1'b0;
                  pre_cnt_in         = pre_cnt_ff - 1'b1;
               end else begin
                  out_char.char_code = dig_char;
                  out_char.last      = (dig_cnt_ff == DIG_CNT_W'(1));
                  dig_in             = dig_ff << 4;
                  dig_cnt_in         = dig_cnt_ff - 1'b1;
                  if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a character or drop one that was taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_char;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      dig_ff      <= dig_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      pre_cnt_ff  <= pre_cnt_in;
      mode_ff     <= mode_in;
      upper_ff    <= upper_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Accepted request always starts work
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // Conversion never runs with an exhausted bit count
   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV |-> bit_cnt_ff != '0)
      else $error("conversion running with zero bits left");

   // Double dabble keeps every digit within 0..9
   a_bcd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && mode_ff == MODE_DEC) |-> bcd_ok)
      else $error("BCD digit out of range during conversion");

   // At least one digit remains while skipping or emitting
   a_dig_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> dig_cnt_ff != '0)
      else $error("digit count ran out before last character");

   // Loading the last character returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_char.last) |=> state_ff == ST_IDLE)
      else $error("last character loaded but sequencer not idle");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for integer_to_ascii_formatter_unit: directed table, then random requests.
// Needs itoa_pkg and the formatter top level; carries its own character predictor.
module tb;
   import itoa_pkg::*;

   localparam int          VALUE_BITS   = 64;
   localparam logic [63:0] VALUE_MASK   = {64{1'b1}} >> (64 - VALUE_BITS);
   localparam int          LIMIT_CYCLES = 400000;
   localparam int          LONG_HOLD    = 200;
   localparam int          DRAIN_CYCLES = 150;

   typedef struct {
      req_type req;
      string   text;   // empty: take the characters from the predictor
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type     pending_chars[$];
   dir_row_type dir_rows[$];
   int       fail_count        = 0;
   int       cycle_count       = 0;
   int       requests_sent     = 0;
   int       dec_requests      = 0;
   int       hex_requests      = 0;
   int       chars_checked     = 0;
   int       sender_gap_max    = 5;
   int       receiver_stall_max = 5;
   int       long_hold_cycles  = 0;

   integer_to_ascii_formatter_unit #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d characters still due",
                  cycle_count, pending_chars.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Format one request into the characters the block should emit
   function automatic void format_chars(input req_type r);
      logic [63:0] v;
      logic [63:0] mag;
      logic [6:0]  alpha;
      logic [3:0]  nib;
      logic [6:0]  digs[$];
      v = r.value & VALUE_MASK;
      if (r.mode == MODE_HEX) begin
         alpha = r.uppercase ? ALPHA_UPPER : ALPHA_LOWER;
         if (r.prefix) begin
            pending_chars.push_back('{char_code: CHAR_ZERO, last: 1'b0});
            pending_chars.push_back('{char_code: CHAR_X, last: 1'b0});
         end
         do begin
            nib = v[3:0];
            digs.push_front(nib > 4'd9 ? alpha + 7'(nib) : CHAR_ZERO + 7'(nib));
            v = v >> 4;
         end while (v != 0);
      end else begin
         // Negate into an unsigned magnitude so the most negative value survives
         mag = v[VALUE_BITS-1] ? ((~v + 64'd1) & VALUE_MASK) : v;
         if (v[VALUE_BITS-1])
            pending_chars.push_back('{char_code: CHAR_MINUS, last: 1'b0});
         do begin
            digs.push_front(CHAR_ZERO + 7'(mag % 64'd10));
            mag = mag / 64'd10;
         end while (mag != 0);
      end
      foreach (digs[i])
         pending_chars.push_back('{char_code: digs[i], last: (i == digs.size() - 1)});
   endfunction

   function automatic void add_row(input logic [63:0] value, input logic mode,
                                   input logic uppercase, input logic prefix,
                                   input string text);
      dir_row_type row;
      row.req = '{value: value, mode: mode, uppercase: uppercase, prefix: prefix};
      row.text = text;
      dir_rows.push_back(row);
   endfunction

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(input req_type r, input string text);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // Queue the characters this request owes
      if (text.len() == 0) begin
         format_chars(r);
      end else begin
         for (int i = 0; i < text.len(); i++)
            pending_chars.push_back('{char_code: 7'(text[i]), last: (i == text.len() - 1)});
      end
      requests_sent++;
      if (r.mode == MODE_HEX) hex_requests++;
      else dec_requests++;
   endtask

   // Random requests, weighted toward digit-count and sign boundaries
   task automatic run_random(input int count);
      req_type     r;
      int          kind;
      int          k;
      logic [63:0] p;
      repeat (count) begin
         kind = $urandom_range(0, 5);
         case (kind)
            0: r.value = {$urandom, $urandom};
            1: r.value = 64'($urandom_range(0, 999));
            2: begin
               k = $urandom_range(1, 64);
               r.value = {$urandom, $urandom} & ({64{1'b1}} >> (64 - k));
            end
            3: r.value = -64'($urandom_range(1, 100000));
            4: begin
               p = 64'd1;
               repeat ($urandom_range(0, 19)) p = p * 64'd10;
               r.value = $urandom_range(0, 1) ? p : p - 64'd1;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0: r.value = 64'h8000_0000_0000_0000;
                  1: r.value = 64'h7FFF_FFFF_FFFF_FFFF;
                  2: r.value = {64{1'b1}};
                  default: r.value = 64'd0;
               endcase
            end
         endcase
         r.mode      = 1'($urandom_range(0, 1));
         r.uppercase = 1'($urandom_range(0, 1));
         r.prefix    = 1'($urandom_range(0, 1));
         send_request(r, "");
      end
   endtask

   // Receiver: stall at random, then take and check one character
   initial begin
      int      stall;
      rsp_type want;
      wait (reset == 1'b0);
      forever begin
         if (long_hold_cycles > 0) begin
            stall = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, receiver_stall_max);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         chars_checked++;
         if (pending_chars.size() == 0) begin
            $error("unexpected character: char_code %h last %b",
                   rsp_data.char_code, rsp_data.last);
            fail_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_data.char_code !== want.char_code) begin
               $error("char_code mismatch: expected %h actual %h",
                      want.char_code, rsp_data.char_code);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last mismatch: expected %b actual %b", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      add_row(64'd0,                 MODE_DEC, 1'b0, 1'b0, "0");
      add_row(64'd0,                 MODE_HEX, 1'b0, 1'b0, "0");
      add_row(64'd0,                 MODE_HEX, 1'b0, 1'b1, "0x0");
      add_row(64'd0,                 MODE_HEX, 1'b1, 1'b1, "0x0");
      add_row(64'd1,                 MODE_DEC, 1'b0, 1'b0, "");
      add_row({64{1'b1}},            MODE_DEC, 1'b0, 1'b0, "-1");
      add_row({64{1'b1}},            MODE_HEX, 1'b1, 1'b0, "FFFFFFFFFFFFFFFF");
      add_row({64{1'b1}},            MODE_HEX, 1'b0, 1'b1, "0xffffffffffffffff");
      add_row(64'h7FFF_FFFF_FFFF_FFFF, MODE_DEC, 1'b0, 1'b0, "9223372036854775807");
      add_row(64'h8000_0000_0000_0000, MODE_DEC, 1'b0, 1'b0, "-9223372036854775808");
      add_row(64'h8000_0000_0000_0000, MODE_HEX, 1'b1, 1'b1, "0x8000000000000000");
      add_row(64'd9,                 MODE_DEC, 1'b0, 1'b0, "");
      add_row(64'd10,                MODE_DEC, 1'b0, 1'b0, "");
      // Case and prefix flags must not change decimal output
      add_row(64'd42,                MODE_DEC, 1'b1, 1'b1, "");
      add_row({64{1'b1}},            MODE_DEC, 1'b1, 1'b1, "");
      add_row(64'hA,                 MODE_HEX, 1'b0, 1'b0, "");
      add_row(64'hF,                 MODE_HEX, 1'b1, 1'b0, "");
      add_row(64'h0123_4567_89AB_CDEF, MODE_HEX, 1'b1, 1'b1, "");
      add_row(64'h0123_4567_89AB_CDEF, MODE_HEX, 1'b0, 1'b0, "");
      add_row(64'd9999999999999999999, MODE_DEC, 1'b0, 1'b0, "");
      add_row(64'd1234567890123456789, MODE_DEC, 1'b1, 1'b0, "");
      add_row(64'h0000_0001_0000_0000, MODE_HEX, 1'b0, 1'b0, "");
      add_row(64'd1000000000000000000, MODE_DEC, 1'b0, 1'b1, "");

      // Hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_request(dir_rows[i].req, dir_rows[i].text);

      run_random(40);

      // Hold off the receiver while requests arrive back to back
      long_hold_cycles = LONG_HOLD;
      sender_gap_max = 0;
      run_random(20);
      sender_gap_max = 5;

      // Pause the sender until every character has drained
      req_valid <= 1'b0;
      wait (pending_chars.size() == 0);
      @(posedge clock);

      // Stretch with no idling on either side
      sender_gap_max = 0;
      receiver_stall_max = 0;
      run_random(25);
      sender_gap_max = 5;
      receiver_stall_max = 5;

      run_random(22);
      req_valid <= 1'b0;

      // Drain, then watch for stray characters
      wait (pending_chars.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests (%0d decimal, %0d hex), %0d characters checked",
               requests_sent, dec_requests, hex_requests, chars_checked);
      $display("including a long receiver hold-off, a drained pause and a no-idle stretch");
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
